@@ rtl/avrpd_pkg.sv @@
// Shared constants, operation codes and small lookup functions of the AVR
// instruction predecoder. No dependencies.

package avrpd_pkg;

	localparam int unsigned WordWidth   = 16;
	localparam int unsigned OutWidth    = 32;
	localparam int unsigned AddrWidth   = 7;
	localparam int unsigned OpWidth     = 7;

	localparam logic [AddrWidth-1:0] PixelPortReset = 7'd40;

	localparam logic [OpWidth-1:0] OpNop   = 7'h00;
	localparam logic [OpWidth-1:0] OpPixel = 7'h49;
	localparam logic [OpWidth-1:0] OpUndef = 7'h4A;

	// Operation of the load/store group, zero where the code is reserved.
	function automatic logic [OpWidth-1:0] ldst_op(input logic [3:0] sub, input logic store);
		logic [OpWidth-1:0] op;
		op = '0;
		if (store) begin
			unique case (sub)
				4'h0: op = 7'h1C;
				4'h1, 4'h9, 4'hD: op = 7'h1F;
				4'h2, 4'hA, 4'hE: op = 7'h1E;
				4'hC: op = 7'h1D;
				4'hF: op = 7'h1A;
				default: op = '0;
			endcase
		end else begin
			unique case (sub)
				4'h0: op = 7'h20;
				4'h1, 4'h9, 4'hD: op = 7'h23;
				4'h2, 4'hA, 4'hE: op = 7'h22;
				4'h4: op = 7'h18;
				4'h5: op = 7'h19;
				4'hC: op = 7'h21;
				4'hF: op = 7'h1B;
				default: op = '0;
			endcase
		end
		return op;
	endfunction

	// Pointer register used by the indirect load/store codes.
	function automatic logic [4:0] ldst_ptr(input logic [3:0] sub);
		logic [4:0] p;
		unique case (sub)
			4'h1, 4'h2: p = 5'd30;
			4'h9, 4'hA: p = 5'd28;
			4'hC, 4'hD, 4'hE: p = 5'd26;
			default: p = 5'd0;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] bit_mask(input logic [2:0] b);
		return 8'h01 << b;
	endfunction

endpackage

@@ rtl/avr_instruction_predecoder.sv @@
// Top level of the AVR instruction predecoder: input stage, result stage and
// the pixel port register. Depends on avrpd_pkg and avrpd_decode.
//
// Usage:
//   The input stream (s_tvalid, s_tready, s_tdata) carries one instruction
//   word and the program word after it per transaction. The output stream
//   (m_tvalid, m_tready, m_tdata) returns one 32-bit predecoded word for
//   every input transaction, in order.
//   The cfg channel writes the data-space address at which an OUT decodes as
//   the pixel operation; cfg_ready is always high. Write it only while no
//   transaction is in flight.
//   An accepted transaction is held in the input register and then in the result
//   register that drives m_tvalid; the decode logic lies between the two.
//   Throughput is one transaction per cycle while the receiver keeps m_tready high.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; s_tready falls only when both are full and
//   m_tready is low.
//   Reset empties both stages and sets the pixel port address to 40.

module avr_instruction_predecoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // first_word [15:0], second_word [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // decoded_word [31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [avrpd_pkg::AddrWidth-1:0] cfg_data
);
	import avrpd_pkg::*;

	logic                 valid_s1;
	logic [31:0]          data_s1;
	logic                 valid_s2;
	logic [OutWidth-1:0]  data_s2;
	logic [AddrWidth-1:0] pixel_port_q;
	logic [OutWidth-1:0]  decoded;
	logic                 adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_port_q <= PixelPortReset;
		end else if (cfg_valid && cfg_ready) begin
			pixel_port_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	avrpd_decode u_decode (
		.first_word         (data_s1[15:0]),
		.second_word        (data_s1[31:16]),
		.pixel_port_address (pixel_port_q),
		.decoded_word       (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= decoded;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Input only backs up when both stages hold a transaction and the sink stalls.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled while a stage was free");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("decoded transaction lost between stages");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !valid_s1) |=> !m_tvalid)
		else $error("result repeated after it was taken");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> (pixel_port_q == $past(cfg_data)))
		else $error("pixel port address not updated");

endmodule

@@ rtl/avrpd_decode.sv @@
// Combinational decode of one AVR instruction word into the predecoded form.
// Depends on avrpd_pkg.

module avrpd_decode (
	input  logic [avrpd_pkg::WordWidth-1:0] first_word,
	input  logic [avrpd_pkg::WordWidth-1:0] second_word,
	input  logic [avrpd_pkg::AddrWidth-1:0] pixel_port_address,
	output logic [avrpd_pkg::OutWidth-1:0]  decoded_word
);
	import avrpd_pkg::*;

	logic [15:0] w;
	logic [6:0]  op;
	logic        two_word;
	logic [7:0]  byte1;
	logic [15:0] upper;
	logic [7:0]  rd5;
	logic [7:0]  rr5;
	logic [7:0]  hi_reg;
	logic [7:0]  imm8;
	logic [6:0]  io_addr;
	logic [6:0]  ldst;
	logic [3:0]  sub;
	logic [3:0]  r5;

	assign w       = first_word;
	assign sub     = w[3:0];
	assign r5      = w[7:4];
	assign rd5     = {3'b000, w[8:4]};
	assign rr5     = {3'b000, w[9], w[3:0]};
	assign hi_reg  = {4'b0001, w[7:4]};
	assign imm8    = {w[11:8], w[3:0]};
	assign io_addr = {1'b0, w[10:9], w[3:0]} + 7'h20;
	assign ldst    = ldst_op(sub, w[9]);

	always_comb begin
		op       = OpUndef;
		two_word = 1'b0;
		byte1    = '0;
		upper    = '0;
		unique case (w[15:10]) inside
			6'h00: begin
				unique case (w[9:8])
					2'd0: op = (w[7:0] == 8'h00) ? OpNop : OpUndef;
					2'd1: begin
						op    = 7'h01;
						byte1 = {3'b000, w[7:4], 1'b0};
						upper = {11'd0, w[3:0], 1'b0};
					end
					2'd2: begin
						op    = 7'h02;
						byte1 = hi_reg;
						upper = {11'd0, 1'b1, w[3:0]};
					end
					default: begin
						op    = 7'h03 + {5'd0, w[7], w[3]};
						byte1 = {3'b000, 2'b10, w[6:4]};
						upper = {11'd0, 2'b10, w[2:0]};
					end
				endcase
			end
			[6'h01:6'h0B]: begin
				op    = 7'h06 + {1'b0, w[15:10]};
				byte1 = rd5;
				upper = {8'd0, rr5};
			end
			[6'h0C:6'h1F]: begin
				op    = 7'h0F + {3'b000, w[15:12]};
				byte1 = hi_reg;
				upper = {8'd0, imm8};
			end
			6'h24: begin
				if (ldst != 7'h00) begin
					op    = ldst;
					byte1 = rd5;
					if (sub == 4'h0) begin
						two_word = 1'b1;
						upper    = second_word;
					end else begin
						upper = {11'd0, ldst_ptr(sub)};
					end
				end
			end
			6'h25: begin
				if (w[9]) begin
					// ADIW and SBIW work on the upper register pairs.
					op    = 7'h3A + {6'd0, w[8]};
					byte1 = {3'b000, 2'b11, w[5:4], 1'b0};
					upper = {10'd0, w[7:6], w[3:0]};
				end else begin
					case (sub) inside
						[4'h0:4'h3]: begin
							op    = 7'h24 + {3'b000, sub};
							byte1 = rd5;
						end
						[4'h5:4'h7]: begin
							op    = 7'h23 + {3'b000, sub};
							byte1 = rd5;
						end
						4'hA: begin
							op    = 7'h2B;
							byte1 = rd5;
						end
						4'h9: op = 7'h30 + {5'd0, w[8], 1'b0};
						[4'hC:4'hF]: begin
							op       = 7'h2C + {6'd0, w[1]};
							two_word = 1'b1;
							upper    = second_word;
						end
						4'h8: begin
							if (!w[8]) begin
								op    = 7'h2E + {6'd0, w[7]};
								byte1 = bit_mask(w[6:4]);
							end else begin
								case (r5) inside
									4'h0: op = 7'h31;
									4'h1: op = 7'h33;
									[4'h8:4'hA]: op = 7'h2C + {3'b000, r5};
									4'hC: op = 7'h18;
									4'hE: op = 7'h17;
									default: op = OpUndef;
								endcase
							end
						end
						default: op = OpUndef;
					endcase
				end
			end
			6'h26: begin
				op    = 7'h3C + {5'd0, w[9:8]};
				byte1 = {3'b000, w[7:3]} + 8'h20;
				upper = {8'd0, bit_mask(w[2:0])};
			end
			6'h27: begin
				op    = 7'h37;
				byte1 = rd5;
				upper = {8'd0, rr5};
			end
			[6'h20:6'h23], [6'h28:6'h2B]: begin
				// Displacement form: pointer Y or Z, then the six-bit offset.
				op    = w[9] ? 7'h1D : 7'h21;
				byte1 = rd5;
				upper = {2'b00, w[13], w[11:10], w[2:0], 3'b000, w[3] ? 5'd28 : 5'd30};
			end
			[6'h2C:6'h2D]: begin
				op    = 7'h38;
				byte1 = rd5;
				upper = {9'd0, io_addr};
			end
			[6'h2E:6'h2F]: begin
				upper = {11'd0, w[8:4]};
				if (io_addr == pixel_port_address) begin
					op = OpPixel;
				end else begin
					op    = 7'h39;
					byte1 = {1'b0, io_addr};
				end
			end
			[6'h30:6'h37]: begin
				op    = 7'h40 + {6'd0, w[12]};
				upper = {{4{w[11]}}, w[11:0]};
			end
			[6'h38:6'h3B]: begin
				op    = 7'h48;
				byte1 = hi_reg;
				upper = {8'd0, imm8};
			end
			[6'h3C:6'h3D]: begin
				op    = 7'h42 + {6'd0, w[10]};
				byte1 = bit_mask(w[2:0]);
				upper = {{9{w[9]}}, w[9:3]};
			end
			6'h3E: begin
				op    = 7'h44 + {6'd0, w[9]};
				byte1 = rd5;
				upper = {13'd0, w[2:0]};
			end
			6'h3F: begin
				op    = 7'h46 + {6'd0, w[9]};
				byte1 = rd5;
				upper = {8'd0, bit_mask(w[2:0])};
			end
			default: op = OpUndef;
		endcase
	end

	assign decoded_word = {upper, byte1, two_word, op};

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for avr_instruction_predecoder: drives instruction fetches,
// predicts each predecoded word and compares it with the output stream.
// Depends on avrpd_pkg and the predecoder RTL.
`timescale 1ns / 100ps

module tb_top;
	import avrpd_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int HoldOffCycles = 300;
	localparam int RandomPerPhase = 117;

	// Internal operation numbers; groups are given by their first member.
	localparam logic [6:0] OpMovw   = 7'h01;
	localparam logic [6:0] OpMuls   = 7'h02;
	localparam logic [6:0] OpMulsu  = 7'h03;
	localparam logic [6:0] OpCpc    = 7'h07;
	localparam logic [6:0] OpCpi    = 7'h12;
	localparam logic [6:0] OpSpm    = 7'h17;
	localparam logic [6:0] OpLpm    = 7'h18;
	localparam logic [6:0] OpLpmInc = 7'h19;
	localparam logic [6:0] OpPush   = 7'h1A;
	localparam logic [6:0] OpPop    = 7'h1B;
	localparam logic [6:0] OpSts    = 7'h1C;
	localparam logic [6:0] OpSt     = 7'h1D;
	localparam logic [6:0] OpStDec  = 7'h1E;
	localparam logic [6:0] OpStInc  = 7'h1F;
	localparam logic [6:0] OpLds    = 7'h20;
	localparam logic [6:0] OpLd     = 7'h21;
	localparam logic [6:0] OpLdDec  = 7'h22;
	localparam logic [6:0] OpLdInc  = 7'h23;
	localparam logic [6:0] OpCom    = 7'h24;
	localparam logic [6:0] OpAsr    = 7'h28;
	localparam logic [6:0] OpDec    = 7'h2B;
	localparam logic [6:0] OpJmp    = 7'h2C;
	localparam logic [6:0] OpBset   = 7'h2E;
	localparam logic [6:0] OpIjmp   = 7'h30;
	localparam logic [6:0] OpRet    = 7'h31;
	localparam logic [6:0] OpReti   = 7'h33;
	localparam logic [6:0] OpSleep  = 7'h34;
	localparam logic [6:0] OpMul    = 7'h37;
	localparam logic [6:0] OpIn     = 7'h38;
	localparam logic [6:0] OpOut    = 7'h39;
	localparam logic [6:0] OpAdiw   = 7'h3A;
	localparam logic [6:0] OpCbi    = 7'h3C;
	localparam logic [6:0] OpRjmp   = 7'h40;
	localparam logic [6:0] OpBrbs   = 7'h42;
	localparam logic [6:0] OpBld    = 7'h44;
	localparam logic [6:0] OpSbrc   = 7'h46;
	localparam logic [6:0] OpLdi    = 7'h48;

	localparam logic [6:0] IoBase = 7'h20;
	localparam logic [4:0] XReg   = 5'd26;
	localparam logic [4:0] YReg   = 5'd28;
	localparam logic [4:0] ZReg   = 5'd30;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
	} fetch_t;

	typedef struct packed {
		logic [15:0] first;
		logic [31:0] word;
	} decode_expect_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [AddrWidth-1:0] cfg_data = '0;

	fetch_t         pending_fetches[$];
	decode_expect_t expected_decodes[$];
	fetch_t         next_fetch;
	decode_expect_t oldest;
	logic [31:0]    predicted;
	logic [6:0]     pixel_addr_model = PixelPortReset;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int fetch_count = 0;
	int pixel_count = 0;
	int settings_count = 1;
	int input_stall_cycles = 0;
	int quiet_cycles = 0;
	logic hold_kick = 1'b0;
	int hold_left = 0;

	avr_instruction_predecoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] predecode(input logic [15:0] w, input logic [15:0] w1,
			input logic [6:0] pix);
		logic [31:0] r;
		logic [5:0]  top;
		logic [6:0]  io;
		logic [6:0]  op;
		logic [4:0]  ptr;
		logic        hit;
		r = '0;
		top = w[15:10];
		io = {1'b0, w[10:9], w[3:0]} + IoBase;
		op = '0;
		ptr = '0;
		hit = 1'b1;
		if (top == 6'h00) begin
			case (w[9:8])
				2'd0: r[6:0] = (w[7:0] == 8'h00) ? OpNop : OpUndef;
				2'd1: begin
					r[6:0] = OpMovw;
					r[12:9] = w[7:4];
					r[20:17] = w[3:0];
				end
				2'd2: begin
					r[6:0] = OpMuls;
					r[12:8] = {1'b1, w[7:4]};
					r[20:16] = {1'b1, w[3:0]};
				end
				default: begin
					r[6:0] = OpMulsu + {5'b0, w[7], w[3]};
					r[12:8] = {2'b10, w[6:4]};
					r[20:16] = {2'b10, w[2:0]};
				end
			endcase
		end else if (top <= 6'h0B) begin
			r[6:0] = OpCpc + {1'b0, top} - 7'd1;
			r[12:8] = w[8:4];
			r[20:16] = {w[9], w[3:0]};
		end else if (top <= 6'h1F) begin
			r[6:0] = OpCpi + {3'b0, w[15:12]} - 7'd3;
			r[12:8] = {1'b1, w[7:4]};
			r[23:16] = {w[11:8], w[3:0]};
		end else if (top == 6'h24) begin
			case ({w[9], w[3:0]})
				5'h00: op = OpLds;
				5'h01, 5'h09, 5'h0D: op = OpLdInc;
				5'h02, 5'h0A, 5'h0E: op = OpLdDec;
				5'h04: op = OpLpm;
				5'h05: op = OpLpmInc;
				5'h0C: op = OpLd;
				5'h0F: op = OpPop;
				5'h10: op = OpSts;
				5'h11, 5'h19, 5'h1D: op = OpStInc;
				5'h12, 5'h1A, 5'h1E: op = OpStDec;
				5'h1C: op = OpSt;
				5'h1F: op = OpPush;
				default: hit = 1'b0;
			endcase
			case (w[3:0])
				4'h1, 4'h2: ptr = ZReg;
				4'h9, 4'hA: ptr = YReg;
				4'hC, 4'hD, 4'hE: ptr = XReg;
				default: ptr = '0;
			endcase
			if (!hit)
				return {25'b0, OpUndef};
			r[6:0] = op;
			r[12:8] = w[8:4];
			r[20:16] = ptr;
			// Direct LDS/STS carry the address word and the two-word flag.
			if (w[3:0] == 4'h0) begin
				r[7] = 1'b1;
				r[31:16] = w1;
			end
		end else if (top == 6'h25) begin
			if (w[9]) begin
				r[6:0] = OpAdiw + {6'b0, w[8]};
				r[12:8] = {2'b11, w[5:4], 1'b0};
				r[21:16] = {w[7:6], w[3:0]};
			end else begin
				case (w[3:0])
					4'h0, 4'h1, 4'h2, 4'h3: begin
						r[6:0] = OpCom + {5'b0, w[1:0]};
						r[12:8] = w[8:4];
					end
					4'h5, 4'h6, 4'h7: begin
						r[6:0] = OpAsr + {3'b0, w[3:0]} - 7'd5;
						r[12:8] = w[8:4];
					end
					4'hA: begin
						r[6:0] = OpDec;
						r[12:8] = w[8:4];
					end
					4'h9: r[6:0] = OpIjmp + {5'b0, w[8], 1'b0};
					4'hC, 4'hD, 4'hE, 4'hF: begin
						r[6:0] = OpJmp + {6'b0, w[1]};
						r[7] = 1'b1;
						r[31:16] = w1;
					end
					4'h8: begin
						if (!w[8]) begin
							r[6:0] = OpBset + {6'b0, w[7]};
							r[15:8] = 8'd1 << w[6:4];
						end else begin
							case (w[7:4])
								4'h0: r[6:0] = OpRet;
								4'h1: r[6:0] = OpReti;
								4'h8, 4'h9, 4'hA: r[6:0] = OpSleep + {5'b0, w[5:4]};
								4'hC: r[6:0] = OpLpm;
								4'hE: r[6:0] = OpSpm;
								default: return {25'b0, OpUndef};
							endcase
						end
					end
					default: return {25'b0, OpUndef};
				endcase
			end
		end else if (top == 6'h26) begin
			r[6:0] = OpCbi + {5'b0, w[9:8]};
			r[15:8] = {3'b0, w[7:3]} + 8'h20;
			r[23:16] = 8'd1 << w[2:0];
		end else if (top == 6'h27) begin
			r[6:0] = OpMul;
			r[12:8] = w[8:4];
			r[20:16] = {w[9], w[3:0]};
		end else if (top <= 6'h2B) begin
			// LDD/STD: bit 3 picks Y over Z, displacement spread over three fields.
			r[6:0] = w[9] ? OpSt : OpLd;
			r[12:8] = w[8:4];
			r[20:16] = w[3] ? YReg : ZReg;
			r[29:24] = {w[13], w[11:10], w[2:0]};
		end else if (top <= 6'h2D) begin
			r[6:0] = OpIn;
			r[12:8] = w[8:4];
			r[22:16] = io;
		end else if (top <= 6'h2F) begin
			if (io == pix) begin
				r[6:0] = OpPixel;
			end else begin
				r[6:0] = OpOut;
				r[14:8] = io;
			end
			r[20:16] = w[8:4];
		end else if (top <= 6'h37) begin
			r[6:0] = OpRjmp + {6'b0, w[12]};
			r[27:16] = w[11:0];
			r[31:28] = {4{w[11]}};
		end else if (top <= 6'h3B) begin
			r[6:0] = OpLdi;
			r[12:8] = {1'b1, w[7:4]};
			r[23:16] = {w[11:8], w[3:0]};
		end else if (top <= 6'h3D) begin
			r[6:0] = OpBrbs + {6'b0, w[10]};
			r[15:8] = 8'd1 << w[2:0];
			r[22:16] = w[9:3];
			r[31:23] = {9{w[9]}};
		end else if (top == 6'h3E) begin
			r[6:0] = OpBld + {6'b0, w[9]};
			r[12:8] = w[8:4];
			r[18:16] = w[2:0];
		end else begin
			r[6:0] = OpSbrc + {6'b0, w[9]};
			r[12:8] = w[8:4];
			r[23:16] = 8'd1 << w[2:0];
		end
		return r;
	endfunction

	// Random instruction words, biased toward the crowded groups and the pixel port.
	function automatic fetch_t random_fetch(input logic [6:0] pix);
		fetch_t f;
		int sel;
		logic [6:0] io_off;
		f.first = 16'($urandom);
		f.second = 16'($urandom);
		sel = $urandom_range(99);
		io_off = pix - IoBase;
		if (sel >= 90) begin
			f.first[15:10] = 6'h00;
			if ($urandom_range(1) == 1)
				f.first[7:0] = 8'h00;
		end else if (sel >= 80) begin
			f.first[15:11] = 5'b10111;
			f.first[10:9] = io_off[5:4];
			f.first[3:0] = io_off[3:0];
		end else if (sel >= 70) begin
			f.first[15:10] = 6'h25;
			f.first[9] = 1'b0;
			f.first[3:0] = 4'h8;
		end else if (sel >= 55) begin
			f.first[15:10] = 6'h24 + 6'($urandom_range(1));
		end
		return f;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] instr,
			input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 20)
			$display("MISMATCH %s: instr %h got %h want %h", what, instr, got, want);
	endtask

	task automatic queue_fetch(input logic [15:0] first, input logic [15:0] second);
		pending_fetches.push_back('{first: first, second: second});
	endtask

	task automatic run_phase(input logic write_cfg, input logic [6:0] pix, input int send_pct,
			input int recv_pct, input logic hold);
		if (write_cfg) begin
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_data <= pix;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			cfg_valid <= 1'b0;
			pixel_addr_model = pix;
			settings_count++;
		end
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold) begin
			@(posedge clk);
			hold_kick <= 1'b1;
			@(posedge clk);
			hold_kick <= 1'b0;
		end
		for (int i = 0; i < RandomPerPhase; i++)
			pending_fetches.push_back(random_fetch(pixel_addr_model));
		// Checked at the falling edge, once the driver's updates have settled.
		while (pending_fetches.size() != 0 || s_tvalid || expected_decodes.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Input side: every accepted transaction gets its predicted word queued.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = predecode(s_tdata[15:0], s_tdata[31:16], pixel_addr_model);
				expected_decodes.push_back('{first: s_tdata[15:0], word: predicted});
				fetch_count++;
				if (predicted[6:0] == OpPixel)
					pixel_count++;
			end
			if (s_tvalid && !s_tready)
				input_stall_cycles++;
			if (!s_tvalid || s_tready) begin
				if (pending_fetches.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_fetch = pending_fetches.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {next_fetch.second, next_fetch.first};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: compare each result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_decodes.size() == 0) begin
					report_mismatch("unexpected result", 16'h0000, m_tdata, 32'h0);
				end else begin
					oldest = expected_decodes.pop_front();
					if (m_tdata !== oldest.word)
						report_mismatch("decoded_word", oldest.first, m_tdata, oldest.word);
				end
			end
			m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick)
			hold_left <= HoldOffCycles;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WatchdogLimit) begin
				$display("Watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes, members of many groups, undefined codes and ignored encoding bits.
		queue_fetch(16'h0000, 16'hFFFF);
		queue_fetch(16'h0055, 16'h0000);
		queue_fetch(16'h01FF, 16'h0000);
		queue_fetch(16'h02FF, 16'hFFFF);
		queue_fetch(16'h0388, 16'h0000);
		queue_fetch(16'h2C00, 16'hFFFF);
		queue_fetch(16'hEFFF, 16'h0000);
		queue_fetch(16'h9000, 16'hFFFF);
		queue_fetch(16'h93FF, 16'h0000);
		queue_fetch(16'h9003, 16'hFFFF);
		queue_fetch(16'h9204, 16'hFFFF);
		queue_fetch(16'h940C, 16'hFFFF);
		queue_fetch(16'h950E, 16'h0000);
		queue_fetch(16'h9419, 16'h0000);
		queue_fetch(16'h9508, 16'h0000);
		queue_fetch(16'h9518, 16'h0000);
		queue_fetch(16'h95C8, 16'h0000);
		queue_fetch(16'h95E8, 16'h0000);
		queue_fetch(16'h95F8, 16'hFFFF);
		queue_fetch(16'h9478, 16'h0000);
		queue_fetch(16'h94F8, 16'h0000);
		queue_fetch(16'h97FF, 16'h0000);
		queue_fetch(16'h9AFF, 16'h0000);
		queue_fetch(16'h9FFF, 16'h0000);
		queue_fetch(16'hAFFF, 16'h0000);
		queue_fetch(16'hB9F8, 16'h0000);
		queue_fetch(16'hCFFF, 16'h0000);
		queue_fetch(16'hD800, 16'h0000);
		queue_fetch(16'hF3FF, 16'h0000);
		queue_fetch(16'hFFFF, 16'hFFFF);
		queue_fetch(16'h8000, 16'h0000);
		queue_fetch(16'h8FFF, 16'h0000);

		run_phase(1'b0, PixelPortReset, 0, 0, 1'b0);
		run_phase(1'b1, 7'd32, 88, 0, 1'b0);
		run_phase(1'b1, 7'd95, 0, 88, 1'b0);
		run_phase(1'b1, 7'd127, 14, 14, 1'b0);
		run_phase(1'b1, 7'd0, 0, 0, 1'b1);
		run_phase(1'b1, 7'($urandom_range(95, 32)), 0, 0, 1'b0);

		$display("Covered %0d instruction words (%0d pixel writes) under %0d port settings.",
			fetch_count, pixel_count, settings_count);
		$display("The input was back-pressured for %0d cycles while results were held off.",
			input_stall_cycles);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
